>>> hdl/l4pc_pkg.sv
// shared constants and types of the l4 port packet classifier
package l4pc_pkg;

	localparam int COUNTER_WIDTH = 64;
	localparam int PORT_W        = 16;
	localparam int EGRESS_W      = 7;
	localparam int ACTION_W      = 2;
	localparam int KEY_W         = PORT_W + 1;
	localparam int TABLE_DEPTH   = 1 << KEY_W;
	localparam int RULE_W        = ACTION_W + EGRESS_W;
	localparam int LEN_W         = 16;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IHL_MIN        = 4'd5;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [LEN_W-1:0] LEN_MAX   = '1;

	// byte offsets inside the frame
	localparam logic [LEN_W-1:0] OFF_ETYPE_HI = 16'd12;
	localparam logic [LEN_W-1:0] OFF_ETYPE_LO = 16'd13;
	localparam logic [LEN_W-1:0] OFF_IHL      = 16'd14;
	localparam logic [LEN_W-1:0] OFF_PROTO    = 16'd23;
	localparam logic [6:0]       L3_START     = 7'd14;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_RULE = 1'b1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE     = 2'd0,
		ACT_PASS     = 2'd1,
		ACT_DROP     = 2'd2,
		ACT_REDIRECT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		VERDICT_PASS     = 2'd0,
		VERDICT_DROP     = 2'd1,
		VERDICT_REDIRECT = 2'd2
	} verdict_t;

	// table lookup request raised on the last byte of a frame
	typedef struct packed {
		logic             fire;
		logic             parsed;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
	} lookup_t;

	// frame waiting for its table read data
	typedef struct packed {
		logic             valid;
		logic             parsed;
		logic [LEN_W-1:0] len;
	} frame_t;

endpackage

>>> hdl/l4pc_ram.sv
// generic single-port ram with registered read
module l4pc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hdl/l4pc_parser.sv
// per-frame header parser producing the rule table key
module l4pc_parser import l4pc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output lookup_t    lookup
);

	logic [LEN_W-1:0]  off_q;
	logic [15:0]       etype_q, etype_n;
	logic [3:0]        hw_q, hw_n;
	logic [7:0]        proto_q, proto_n;
	logic [PORT_W-1:0] dport_q, dport_n;
	logic [6:0]        tp;
	logic [LEN_W-1:0]  len;
	logic              parsed;

	always_comb begin
		etype_n = etype_q;
		if (off_q == OFF_ETYPE_HI) begin
			etype_n[15:8] = data_byte;
		end
		if (off_q == OFF_ETYPE_LO) begin
			etype_n[7:0] = data_byte;
		end
		hw_n    = (off_q == OFF_IHL) ? data_byte[3:0] : hw_q;
		proto_n = (off_q == OFF_PROTO) ? data_byte : proto_q;
		// transport header start; the ihl byte itself never hits the port offsets
		tp      = L3_START + {1'b0, hw_n, 2'b00};
		dport_n = dport_q;
		if (off_q == {9'd0, tp + 7'd2}) begin
			dport_n[15:8] = data_byte;
		end
		if (off_q == {9'd0, tp + 7'd3}) begin
			dport_n[7:0] = data_byte;
		end
		len    = (off_q == LEN_MAX) ? LEN_MAX : off_q + 16'd1;
		parsed = (etype_n == ETHERTYPE_IPV4) && (hw_n >= IHL_MIN) &&
			((proto_n == PROTO_TCP) || (proto_n == PROTO_UDP)) &&
			(len >= {9'd0, tp + 7'd4});
		lookup.fire   = accept && last_byte;
		lookup.parsed = parsed;
		lookup.key    = {proto_n == PROTO_UDP, dport_n};
		lookup.len    = len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			etype_q <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			dport_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				off_q   <= '0;
				etype_q <= '0;
				hw_q    <= '0;
				proto_q <= '0;
				dport_q <= '0;
			end else begin
				off_q   <= len;
				etype_q <= etype_n;
				hw_q    <= hw_n;
				proto_q <= proto_n;
				dport_q <= dport_n;
			end
		end
	end

endmodule

>>> hdl/l4pc_stats.sv
// verdict decode, traffic counters and result register
module l4pc_stats import l4pc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  frame_t                   frame_s1,
	input  logic [RULE_W-1:0]        rule_s1,
	input  logic                     out_ready,
	output logic                     stall,
	output logic                     out_valid,
	output logic [1:0]               verdict,
	output logic [EGRESS_W-1:0]      egress_port,
	output logic [LEN_W-1:0]         frame_length,
	output logic                     rule_hit,
	output logic [COUNTER_WIDTH-1:0] forwarded_count,
	output logic [COUNTER_WIDTH-1:0] forwarded_bytes,
	output logic [COUNTER_WIDTH-1:0] dropped_count
);

	logic                     valid_q;
	logic                     load;
	action_t                  act;
	verdict_t                 vd;
	logic [EGRESS_W-1:0]      eg;
	logic                     hit;
	logic [1:0]               verdict_q;
	logic [EGRESS_W-1:0]      egress_q;
	logic [LEN_W-1:0]         len_q;
	logic                     hit_q;
	logic [COUNTER_WIDTH-1:0] fwd_q, fwd_bytes_q, drop_q;

	assign stall = valid_q && !out_ready;
	assign load  = frame_s1.valid && !stall;

	always_comb begin
		act = frame_s1.parsed ? action_t'(rule_s1[RULE_W-1 -: ACTION_W]) : ACT_NONE;
		hit = act != ACT_NONE;
		vd  = VERDICT_PASS;
		eg  = '0;
		unique case (act)
			ACT_DROP: vd = VERDICT_DROP;
			ACT_REDIRECT: begin
				vd = VERDICT_REDIRECT;
				eg = rule_s1[EGRESS_W-1:0];
			end
			default: vd = VERDICT_PASS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			fwd_q       <= '0;
			fwd_bytes_q <= '0;
			drop_q      <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				if (vd == VERDICT_DROP) begin
					drop_q <= drop_q + 1'b1;
				end else begin
					fwd_q       <= fwd_q + 1'b1;
					fwd_bytes_q <= fwd_bytes_q + COUNTER_WIDTH'(frame_s1.len);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= vd;
			egress_q  <= eg;
			len_q     <= frame_s1.len;
			hit_q     <= hit;
		end
	end

	// counters change only when a new item loads, so they double as result fields
	assign out_valid       = valid_q;
	assign verdict         = verdict_q;
	assign egress_port     = egress_q;
	assign frame_length    = len_q;
	assign rule_hit        = hit_q;
	assign forwarded_count = fwd_q;
	assign forwarded_bytes = fwd_bytes_q;
	assign dropped_count   = drop_q;

endmodule

>>> hdl/l4_port_packet_classifier.sv
// top level of the l4 port packet classifier
// Frames enter one byte per item and rule writes enter as items of their own; the block
// takes one item every clock cycle while results are being taken. The rule table is a
// 131072 x 9 single-port ram: a rule write or the lookup for a frame's last byte uses the
// port in the cycle the item is accepted, and the result is registered after the ram read
// for the last byte. After reset the table is cleared one entry a cycle, with in_ready low.
module l4_port_packet_classifier import l4pc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	input  logic                     rule_is_udp,
	input  logic [PORT_W-1:0]        rule_port,
	input  logic [ACTION_W-1:0]      rule_action,
	input  logic [EGRESS_W-1:0]      rule_egress,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               verdict,
	output logic [EGRESS_W-1:0]      egress_port,
	output logic [LEN_W-1:0]         frame_length,
	output logic                     rule_hit,
	output logic [COUNTER_WIDTH-1:0] forwarded_count,
	output logic [COUNTER_WIDTH-1:0] forwarded_bytes,
	output logic [COUNTER_WIDTH-1:0] dropped_count
);

	logic              clearing_q;
	logic [KEY_W-1:0]  clr_addr_q;
	logic              accept;
	logic              byte_accept;
	logic              rule_accept;
	logic              stall;
	lookup_t           lookup;
	frame_t            frame_s1;
	logic [KEY_W-1:0]  key_s1;
	logic              ram_we;
	logic [KEY_W-1:0]  ram_addr;
	logic [RULE_W-1:0] ram_wdata;
	logic [RULE_W-1:0] ram_rdata;

	// hold input while a frame waits on a stalled result, so its read data stays put
	assign in_ready    = !clearing_q && !(frame_s1.valid && stall);
	assign accept      = in_valid && in_ready;
	assign byte_accept = accept && (operation == OP_BYTE);
	assign rule_accept = accept && (operation == OP_RULE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	l4pc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (byte_accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.lookup    (lookup)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = lookup.key;
		ram_wdata = '0;
		if (clearing_q) begin
			ram_we   = 1'b1;
			ram_addr = clr_addr_q;
		end else if (rule_accept) begin
			ram_we    = 1'b1;
			ram_addr  = {rule_is_udp, rule_port};
			ram_wdata = {rule_action, rule_egress};
		end else if (frame_s1.valid && stall) begin
			// keep re-reading the waiting frame's entry
			ram_addr = key_s1;
		end
	end

	l4pc_ram #(
		.WIDTH (RULE_W),
		.DEPTH (TABLE_DEPTH)
	) u_rule_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_s1 <= '0;
			key_s1   <= '0;
		end else if (lookup.fire) begin
			frame_s1.valid  <= 1'b1;
			frame_s1.parsed <= lookup.parsed;
			frame_s1.len    <= lookup.len;
			key_s1          <= lookup.key;
		end else if (!stall) begin
			frame_s1.valid <= 1'b0;
		end
	end

	l4pc_stats u_stats (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_s1        (frame_s1),
		.rule_s1         (ram_rdata),
		.out_ready       (out_ready),
		.stall           (stall),
		.out_valid       (out_valid),
		.verdict         (verdict),
		.egress_port     (egress_port),
		.frame_length    (frame_length),
		.rule_hit        (rule_hit),
		.forwarded_count (forwarded_count),
		.forwarded_bytes (forwarded_bytes),
		.dropped_count   (dropped_count)
	);

endmodule

>>> dv/classify_checker.sv
// checker for the l4 port packet classifier: predicts each result and compares it
`timescale 1ns / 1ps

module classify_checker import l4pc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     operation,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	input  logic                     rule_is_udp,
	input  logic [PORT_W-1:0]        rule_port,
	input  logic [ACTION_W-1:0]      rule_action,
	input  logic [EGRESS_W-1:0]      rule_egress,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [1:0]               verdict,
	input  logic [EGRESS_W-1:0]      egress_port,
	input  logic [LEN_W-1:0]         frame_length,
	input  logic                     rule_hit,
	input  logic [COUNTER_WIDTH-1:0] forwarded_count,
	input  logic [COUNTER_WIDTH-1:0] forwarded_bytes,
	input  logic [COUNTER_WIDTH-1:0] dropped_count,
	output int                       fail_count,
	output int                       results_pending
);

	typedef struct {
		verdict_t                 verdict;
		logic [EGRESS_W-1:0]      egress;
		logic [LEN_W-1:0]         len;
		logic                     hit;
		logic [COUNTER_WIDTH-1:0] fwd_pkts;
		logic [COUNTER_WIDTH-1:0] fwd_bytes;
		logic [COUNTER_WIDTH-1:0] drop_pkts;
	} frame_verdict_t;

	frame_verdict_t           verdict_q[$];
	logic [RULE_W-1:0]        rules [TABLE_DEPTH];
	int                       frame_pos;
	logic [15:0]              etype;
	logic [3:0]               ihl;
	logic [7:0]               proto;
	logic [15:0]              dport;
	logic [COUNTER_WIDTH-1:0] fwd_pkts;
	logic [COUNTER_WIDTH-1:0] fwd_bytes;
	logic [COUNTER_WIDTH-1:0] drop_pkts;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			rules[i] = '0;
	end

	task automatic clear_frame();
		frame_pos = 0;
		etype     = '0;
		ihl       = '0;
		proto     = '0;
		dport     = '0;
	endtask

	task automatic classify_byte(input logic [7:0] b, input logic last);
		int               tp;
		int               len;
		logic             parsed;
		logic [KEY_W-1:0] key;
		action_t          act;
		frame_verdict_t   r;
		if (frame_pos == OFF_ETYPE_HI) etype[15:8] = b;
		if (frame_pos == OFF_ETYPE_LO) etype[7:0] = b;
		if (frame_pos == OFF_IHL) ihl = b[3:0];
		if (frame_pos == OFF_PROTO) proto = b;
		// destination port sits at bytes 2..3 of the transport header
		tp = int'(L3_START) + 4 * int'(ihl);
		if (frame_pos == tp + 2) dport[15:8] = b;
		if (frame_pos == tp + 3) dport[7:0] = b;
		len = (frame_pos >= int'(LEN_MAX)) ? int'(LEN_MAX) : frame_pos + 1;
		if (!last) begin
			frame_pos = len;
			return;
		end
		parsed = etype == ETHERTYPE_IPV4 && ihl >= IHL_MIN &&
			(proto == PROTO_TCP || proto == PROTO_UDP) && len >= tp + 4;
		key = {proto == PROTO_UDP, dport};
		act = action_t'(rules[key][RULE_W-1:EGRESS_W]);
		r.verdict = VERDICT_PASS;
		r.egress  = '0;
		r.hit     = 1'b0;
		if (parsed) begin
			r.hit = act != ACT_NONE;
			if (act == ACT_DROP) begin
				r.verdict = VERDICT_DROP;
			end else if (act == ACT_REDIRECT) begin
				r.verdict = VERDICT_REDIRECT;
				r.egress  = rules[key][EGRESS_W-1:0];
			end
		end
		if (r.verdict == VERDICT_DROP) begin
			drop_pkts = drop_pkts + 1'b1;
		end else begin
			fwd_pkts  = fwd_pkts + 1'b1;
			fwd_bytes = fwd_bytes + COUNTER_WIDTH'(len);
		end
		r.len       = LEN_W'(len);
		r.fwd_pkts  = fwd_pkts;
		r.fwd_bytes = fwd_bytes;
		r.drop_pkts = drop_pkts;
		verdict_q.push_back(r);
		clear_frame();
	endtask

	task automatic check_field(input string name, input logic [COUNTER_WIDTH-1:0] want,
		input logic [COUNTER_WIDTH-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t w;
		if (!arst_n) begin
			clear_frame();
			fwd_pkts  = '0;
			fwd_bytes = '0;
			drop_pkts = '0;
			verdict_q.delete();
		end else begin
			// compare first: a result never belongs to an item taken at the same edge
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$error("result with no frame waiting for it");
					fail_count++;
				end else begin
					w = verdict_q.pop_front();
					check_field("verdict", w.verdict, verdict);
					check_field("egress_port", w.egress, egress_port);
					check_field("frame_length", w.len, frame_length);
					check_field("rule_hit", w.hit, rule_hit);
					check_field("forwarded_count", w.fwd_pkts, forwarded_count);
					check_field("forwarded_bytes", w.fwd_bytes, forwarded_bytes);
					check_field("dropped_count", w.drop_pkts, dropped_count);
				end
			end
			if (in_valid && in_ready) begin
				if (operation == OP_RULE)
					rules[{rule_is_udp, rule_port}] = {rule_action, rule_egress};
				else
					classify_byte(data_byte, last_byte);
			end
		end
		results_pending = verdict_q.size();
	end

endmodule

>>> dv/testbench.sv
// top of the l4 port packet classifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import l4pc_pkg::*;

	localparam int HOLD_CYCLES = 400;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     operation;
	logic [7:0]               data_byte;
	logic                     last_byte;
	logic                     rule_is_udp;
	logic [PORT_W-1:0]        rule_port;
	logic [ACTION_W-1:0]      rule_action;
	logic [EGRESS_W-1:0]      rule_egress;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               verdict;
	logic [EGRESS_W-1:0]      egress_port;
	logic [LEN_W-1:0]         frame_length;
	logic                     rule_hit;
	logic [COUNTER_WIDTH-1:0] forwarded_count;
	logic [COUNTER_WIDTH-1:0] forwarded_bytes;
	logic [COUNTER_WIDTH-1:0] dropped_count;
	int                       fail_count;
	int                       results_pending;

	int          sender_idle_pct;
	int          stall_pct;
	int          hold_requests;
	int          item_count;
	logic [7:0]  frame_buf[$];
	logic [15:0] hot_ports[6] = '{16'd0, 16'hffff, 16'd80, 16'd443, 16'd53, 16'd8080};

	l4_port_packet_classifier i_dut (.*);

	classify_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#24_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left   = 0;
		out_ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = $urandom_range(99) >= stall_pct;
			end
		end
	end

	task automatic drive_item(input logic op, input logic [7:0] b, input logic last,
		input logic udp, input logic [PORT_W-1:0] port, input logic [ACTION_W-1:0] act,
		input logic [EGRESS_W-1:0] eg);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		operation   = op;
		data_byte   = b;
		last_byte   = last;
		rule_is_udp = udp;
		rule_port   = port;
		rule_action = act;
		rule_egress = eg;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		item_count++;
	endtask

	task automatic send_rule(input logic udp, input logic [PORT_W-1:0] port,
		input logic [ACTION_W-1:0] act, input logic [EGRESS_W-1:0] eg);
		drive_item(OP_RULE, 8'($urandom), 1'($urandom_range(1)), udp, port, act, eg);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		drive_item(OP_BYTE, b, last, 1'($urandom_range(1)), 16'($urandom), 2'($urandom),
			7'($urandom));
	endtask

	function automatic logic [15:0] pick_port();
		return ($urandom_range(4) != 0) ? hot_ports[$urandom_range(5)] : 16'($urandom);
	endfunction

	task automatic send_random_rule();
		send_rule(1'($urandom_range(1)), pick_port(), 2'($urandom), 7'($urandom));
	endtask

	// random bytes with the ethertype, ihl, protocol and port placed at their offsets
	task automatic make_frame(input logic [15:0] etype, input logic [3:0] ihl,
		input logic [7:0] proto, input logic [15:0] port, input int len);
		int         tp;
		logic [7:0] b;
		frame_buf.delete();
		tp = int'(L3_START) + 4 * int'(ihl);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == OFF_ETYPE_HI) b = etype[15:8];
			if (i == OFF_ETYPE_LO) b = etype[7:0];
			if (i == OFF_IHL) b[3:0] = ihl;
			if (i == OFF_PROTO) b = proto;
			if (i == tp + 2) b = port[15:8];
			if (i == tp + 3) b = port[7:0];
			frame_buf.push_back(b);
		end
	endtask

	task automatic send_frame(input int rule_pct);
		foreach (frame_buf[i]) begin
			if (rule_pct > 0 && $urandom_range(99) < rule_pct)
				send_random_rule();
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	initial begin
		int          frames;
		int          kind;
		int          len;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] etype;
		sender_idle_pct = 0;
		stall_pct       = 0;
		hold_requests   = 0;
		item_count      = 0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		operation       = OP_BYTE;
		data_byte       = '0;
		last_byte       = 1'b0;
		rule_is_udp     = 1'b0;
		rule_port       = '0;
		rule_action     = ACT_NONE;
		rule_egress     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every action, port and egress extremes, each reason a key is not parsed
		send_rule(1'b0, 16'd80, ACT_PASS, 7'd5);
		send_rule(1'b1, 16'd53, ACT_DROP, 7'd3);
		send_rule(1'b0, 16'hffff, ACT_REDIRECT, 7'd127);
		send_rule(1'b1, 16'd0, ACT_REDIRECT, 7'd0);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 40);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'd53, 78);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'hffff, 38);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd6, PROTO_UDP, 16'd0, 45);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd80, 38);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd1234, 50);
		send_frame(0);
		make_frame(16'h86dd, 4'd5, PROTO_TCP, 16'd80, 40);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 16'd80, 40);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd5, 8'd1, 16'd80, 40);
		send_frame(0);
		// ends one byte short of the full port, then exactly on it
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 37);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 38);
		send_frame(0);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 1);
		send_frame(0);
		// rule rewritten while a frame for that key is in flight
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 40);
		foreach (frame_buf[i]) begin
			if (i == 20)
				send_rule(1'b0, 16'd80, ACT_DROP, 7'd9);
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
		send_rule(1'b0, 16'd80, ACT_NONE, 7'd127);
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 40);
		send_frame(0);
		// long frame: the length saturates
		make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'hffff, 65537);
		send_frame(0);

		// receiver holds off while short frames keep coming, so the block backs up
		hold_requests++;
		repeat (64) begin
			make_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, $urandom_range(1, 3));
			send_frame(0);
		end

		frames = 0;
		while (item_count < 450 || frames < 48) begin
			case ((frames / 6) % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 72; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 72; end
				default: begin sender_idle_pct = 11; stall_pct = 11; end
			endcase
			if ($urandom_range(99) < 30)
				send_random_rule();
			etype = ETHERTYPE_IPV4;
			ihl   = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(6, 15));
			proto = $urandom_range(1) ? PROTO_UDP : PROTO_TCP;
			len   = int'(L3_START) + 4 * int'(ihl) + 4 + $urandom_range(0, 8);
			kind  = $urandom_range(99);
			// most frames are well formed; the rest change one of ethertype, ihl, protocol or length
			if (kind >= 70) begin
				case (kind % 5)
					0: etype = 16'($urandom);
					1: ihl = 4'($urandom_range(0, 4));
					2: proto = 8'($urandom);
					3: len = $urandom_range(1, len - 1);
					default: len = $urandom_range(1, 14);
				endcase
			end
			make_frame(etype, ihl, proto, pick_port(), len);
			send_frame(3);
			frames++;
		end
		in_valid  = 1'b0;
		stall_pct = 0;

		wait (results_pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> l4_port_packet_classifier.f
hdl/l4pc_pkg.sv
hdl/l4pc_ram.sv
hdl/l4pc_parser.sv
hdl/l4pc_stats.sv
hdl/l4_port_packet_classifier.sv
dv/classify_checker.sv
dv/testbench.sv
